// ===== src/fnpll_pkg.sv =====
// Shared constants and codes for the fractional-N divider calculator.
package fnpll_pkg;

    localparam logic [32:0] RF_OUT_MAX_HZ       = 33'd4400000000;
    localparam logic [32:0] RF_OUT_MIN_HZ       = 33'd34375000;
    localparam logic [31:0] REF_IN_MAX_HZ       = 32'd250000000;
    localparam logic [33:0] VCO_MIN_HZ          = 34'd2200000000;
    localparam logic [32:0] PRESCALER_SWITCH_HZ = 33'd3600000000;
    localparam logic [24:0] PFD_MAX_HZ          = 25'd32000000;

    localparam logic [9:0]  R_LIMIT      = 10'd1023;
    localparam logic [2:0]  SEL_MAX      = 3'd6;
    localparam logic [15:0] NMIN_HIGH    = 16'd75;
    localparam logic [15:0] NMIN_LOW     = 16'd23;
    localparam logic [15:0] INT_MAX      = 16'd65535;
    localparam logic [25:0] FIELD12_MAX  = 26'd4095;
    localparam logic [25:0] MOD_SPUR_MIN = 26'd50;
    localparam logic [24:0] PFD_BAND_MAX = 25'd90;
    localparam logic [27:0] BDIV_MAX     = 28'd255;
    localparam logic [26:0] BAND_LIM0    = 27'd500000;
    localparam logic [26:0] BAND_LIM1    = 27'd125000;

    // Configuration register indexes
    localparam logic [2:0] CFG_FEEDBACK  = 3'd0;
    localparam logic [2:0] CFG_BAND_MODE = 3'd1;
    localparam logic [2:0] CFG_DOUBLER   = 3'd2;
    localparam logic [2:0] CFG_HALVER    = 3'd3;
    localparam logic [2:0] CFG_LOW_SPUR  = 3'd4;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_RF_RANGE   = 4'd1,
        ST_REF_RANGE  = 4'd2,
        ST_R_RANGE    = 4'd3,
        ST_N_RANGE    = 4'd4,
        ST_INT_RANGE  = 4'd5,
        ST_MOD_RANGE  = 4'd6,
        ST_FRAC_RANGE = 4'd7,
        ST_PFD_RANGE  = 4'd8,
        ST_BAND_RANGE = 4'd9,
        ST_MISMATCH   = 4'd10
    } status_t;

endpackage

// ===== src/frac_n_pll_divider_calc.sv =====
// Fractional-N synthesizer divider calculator with a bit-serial divider and multiplier.
//
// Usage: drive rf_out_hz, ref_in_hz and channel_spacing_hz and pulse start while
// busy is low; that edge takes the request and busy rises. When the result is
// ready, done is high for exactly one cycle with all result ports valid, and
// busy falls in that same cycle. The receiver cannot stall; the result is held
// on the ports until the next request finishes.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write one mode bit per
// beat. cfg_ready is always high; write only while busy is low.
// Sequence: for an rf or reference range error, S_CHECK passes straight to S_FAIL,
// which raises done without running the search or the arithmetic units.
// The R search takes one cycle per candidate divider (at most 16, since the
// reference is range checked first); each division runs through a shared
// restoring divider at one quotient bit per cycle (up to seven divisions), the
// three products through a shift-add multiplier at one bit per cycle, and the
// GCD through a binary GCD at one step per cycle. One request is worked on at a
// time; the next start is taken from the cycle in which done is high.
// Reset: rst_n (asynchronous, active low) returns to idle and restores the
// mode bits to their defaults (VCO feedback on, all others off).
module frac_n_pll_divider_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [32:0] rf_out_hz,
    input  logic [31:0] ref_in_hz,
    input  logic [31:0] channel_spacing_hz,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic        cfg_data,
    output logic        done,
    output logic [3:0]  status,
    output logic [15:0] int_value,
    output logic [11:0] frac_value,
    output logic [11:0] mod_value,
    output logic        prescaler_high,
    output logic [9:0]  r_value,
    output logic [2:0]  rf_div_select,
    output logic [7:0]  band_clock_divider,
    output logic [32:0] rf_out_calc_hz
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_DIVSEL, S_RSRCH, S_PFD_W, S_NINT_W, S_MOD_W, S_X_W,
        S_FRAC_W, S_GCD, S_GM_W, S_GF_W, S_LIMITS, S_BAND, S_T_W, S_TOP_W,
        S_CALC_W, S_FAIL
    } state_t;

    state_t state_reg;
    logic   busy_reg, done_reg;

    logic fb_reg, band_reg, dbl_reg, hlv_reg, spur_reg;

    logic [32:0] rf_reg;
    logic [31:0] ref_reg, sp_reg;
    logic [33:0] vco_reg;
    logic [2:0]  sel_reg;
    logic        presc_reg;
    logic [9:0]  r_reg;
    logic [35:0] thr_reg;
    logic [32:0] aref_reg;
    logic [24:0] pfd_reg, rem_reg;
    logic [15:0] nint_reg;
    logic [25:0] mod_reg, frac_reg, ga_reg, gb_reg, g_reg;
    logic [4:0]  gk_reg;
    logic [7:0]  bdiv_reg;
    fnpll_pkg::status_t fail_reg;

    fnpll_pkg::status_t status_reg;
    logic [15:0] int_out_reg;
    logic [11:0] frac_out_reg, mod_out_reg;
    logic        presc_out_reg;
    logic [9:0]  r_out_reg;
    logic [2:0]  sel_out_reg;
    logic [7:0]  bdiv_out_reg;
    logic [32:0] calc_out_reg;

    // shared restoring divider
    logic        div_go_reg, dbusy_reg;
    logic [52:0] div_num_reg, dq_reg;
    logic [32:0] div_den_reg, drem_reg;
    logic [5:0]  dcnt_reg;
    logic [34:0] div_trial;

    // shared shift-add multiplier
    logic        mul_go_reg, mbusy_reg;
    logic [52:0] mul_a_reg, ma_reg, macc_reg;
    logic [25:0] mul_b_reg, mb_reg;

    logic        units_idle;
    logic [33:0] num_sel;
    logic [27:0] bdiv_raw;
    logic [25:0] mod_forced;
    logic [25:0] g_calc;

    assign units_idle = !div_go_reg && !dbusy_reg && !mul_go_reg && !mbusy_reg;
    assign div_trial  = {1'b0, drem_reg, dq_reg[52]} - {2'b00, div_den_reg};
    assign num_sel    = fb_reg ? vco_reg : {1'b0, rf_reg};
    assign bdiv_raw   = band_reg ? {2'b00, pfd_reg, 1'b0} : {pfd_reg, 3'b000};
    assign mod_forced = (mod_reg == 26'd1) ? 26'd2 : mod_reg;
    assign g_calc     = (ga_reg == 26'd0) ? (gb_reg << gk_reg) : (ga_reg << gk_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (div_go_reg)
        begin
            dq_reg    <= div_num_reg;
            drem_reg  <= '0;
            dcnt_reg  <= 6'd53;
            dbusy_reg <= 1'b1;
        end
        else if (dbusy_reg)
        begin
            if (div_trial[34])
                drem_reg <= {drem_reg[31:0], dq_reg[52]};
            else
                drem_reg <= div_trial[32:0];
            dq_reg   <= {dq_reg[51:0], ~div_trial[34]};
            dcnt_reg <= dcnt_reg - 6'd1;
            if (dcnt_reg == 6'd1)
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mbusy_reg <= 1'b0;
        else if (mul_go_reg)
        begin
            ma_reg    <= mul_a_reg;
            mb_reg    <= mul_b_reg;
            macc_reg  <= '0;
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg)
        begin
            if (mb_reg == 26'd0)
                mbusy_reg <= 1'b0;
            else
            begin
                if (mb_reg[0])
                    macc_reg <= macc_reg + ma_reg;
                ma_reg <= {ma_reg[51:0], 1'b0};
                mb_reg <= {1'b0, mb_reg[25:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg   <= 1'b1;
            band_reg <= 1'b0;
            dbl_reg  <= 1'b0;
            hlv_reg  <= 1'b0;
            spur_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fnpll_pkg::CFG_FEEDBACK:  fb_reg   <= cfg_data;
                fnpll_pkg::CFG_BAND_MODE: band_reg <= cfg_data;
                fnpll_pkg::CFG_DOUBLER:   dbl_reg  <= cfg_data;
                fnpll_pkg::CFG_HALVER:    hlv_reg  <= cfg_data;
                fnpll_pkg::CFG_LOW_SPUR:  spur_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            status_reg <= fnpll_pkg::ST_OK;
        end
        else
        begin
            done_reg   <= 1'b0;
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rf_reg    <= rf_out_hz;
                        ref_reg   <= ref_in_hz;
                        sp_reg    <= channel_spacing_hz;
                        busy_reg  <= 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    vco_reg   <= {1'b0, rf_reg};
                    sel_reg   <= '0;
                    presc_reg <= rf_reg > fnpll_pkg::PRESCALER_SWITCH_HZ;
                    if (rf_reg > fnpll_pkg::RF_OUT_MAX_HZ || rf_reg < fnpll_pkg::RF_OUT_MIN_HZ)
                    begin
                        fail_reg  <= fnpll_pkg::ST_RF_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else if (ref_reg > fnpll_pkg::REF_IN_MAX_HZ)
                    begin
                        fail_reg  <= fnpll_pkg::ST_REF_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else
                        state_reg <= S_DIVSEL;
                end
                S_DIVSEL:
                begin
                    if (vco_reg < fnpll_pkg::VCO_MIN_HZ && sel_reg < fnpll_pkg::SEL_MAX)
                    begin
                        vco_reg <= {vco_reg[32:0], 1'b0};
                        sel_reg <= sel_reg + 3'd1;
                    end
                    else
                    begin
                        r_reg     <= 10'd1;
                        thr_reg   <= hlv_reg ? {10'd0, fnpll_pkg::PFD_MAX_HZ, 1'b0}
                                             : {11'd0, fnpll_pkg::PFD_MAX_HZ};
                        aref_reg  <= dbl_reg ? {ref_reg, 1'b0} : {1'b0, ref_reg};
                        state_reg <= S_RSRCH;
                    end
                end
                // floor(A/B) < PFD_MAX exactly when A < PFD_MAX * B
                S_RSRCH:
                begin
                    if ({3'd0, aref_reg} < thr_reg)
                    begin
                        div_num_reg <= {20'd0, aref_reg};
                        div_den_reg <= hlv_reg ? {22'd0, r_reg, 1'b0} : {23'd0, r_reg};
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_PFD_W;
                    end
                    else if (r_reg == fnpll_pkg::R_LIMIT)
                    begin
                        fail_reg  <= fnpll_pkg::ST_R_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else
                    begin
                        r_reg   <= r_reg + 10'd1;
                        thr_reg <= thr_reg + (hlv_reg ? {10'd0, fnpll_pkg::PFD_MAX_HZ, 1'b0}
                                                      : {11'd0, fnpll_pkg::PFD_MAX_HZ});
                    end
                end
                S_PFD_W:
                begin
                    if (units_idle)
                    begin
                        pfd_reg <= dq_reg[24:0];
                        if (dq_reg[24:0] == 25'd0)
                        begin
                            fail_reg  <= fnpll_pkg::ST_N_RANGE;
                            state_reg <= S_FAIL;
                        end
                        else
                        begin
                            div_num_reg <= {19'd0, num_sel};
                            div_den_reg <= {8'd0, dq_reg[24:0]};
                            div_go_reg  <= 1'b1;
                            state_reg   <= S_NINT_W;
                        end
                    end
                end
                // N bounds checked on quotient and remainder
                S_NINT_W:
                begin
                    if (units_idle)
                    begin
                        nint_reg <= dq_reg[15:0];
                        rem_reg  <= drem_reg[24:0];
                        if (dq_reg < {37'd0, presc_reg ? fnpll_pkg::NMIN_HIGH
                                                       : fnpll_pkg::NMIN_LOW}
                            || dq_reg[52:16] != 37'd0
                            || (dq_reg[15:0] == fnpll_pkg::INT_MAX && drem_reg != 33'd0))
                        begin
                            fail_reg  <= fnpll_pkg::ST_N_RANGE;
                            state_reg <= S_FAIL;
                        end
                        else if (sp_reg == 32'd0)
                        begin
                            fail_reg  <= fnpll_pkg::ST_MOD_RANGE;
                            state_reg <= S_FAIL;
                        end
                        else
                        begin
                            div_num_reg <= 53'({pfd_reg, 1'b0}) + 53'(sp_reg);
                            div_den_reg <= {sp_reg, 1'b0};
                            div_go_reg  <= 1'b1;
                            state_reg   <= S_MOD_W;
                        end
                    end
                end
                S_MOD_W:
                begin
                    if (units_idle)
                    begin
                        mod_reg    <= dq_reg[25:0];
                        mul_a_reg  <= {28'd0, rem_reg};
                        mul_b_reg  <= dq_reg[25:0];
                        mul_go_reg <= 1'b1;
                        state_reg  <= S_X_W;
                    end
                end
                S_X_W:
                begin
                    if (units_idle)
                    begin
                        div_num_reg <= macc_reg;
                        div_den_reg <= {8'd0, pfd_reg};
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_FRAC_W;
                    end
                end
                S_FRAC_W:
                begin
                    if (units_idle)
                    begin
                        // round half up
                        frac_reg  <= dq_reg[25:0]
                                   + (({drem_reg, 1'b0} >= {9'd0, pfd_reg}) ? 26'd1 : 26'd0);
                        ga_reg    <= mod_reg;
                        gb_reg    <= dq_reg[25:0]
                                   + (({drem_reg, 1'b0} >= {9'd0, pfd_reg}) ? 26'd1 : 26'd0);
                        gk_reg    <= '0;
                        state_reg <= S_GCD;
                    end
                end
                // binary GCD, one step per cycle
                S_GCD:
                begin
                    if (ga_reg == 26'd0 || gb_reg == 26'd0)
                    begin
                        g_reg <= g_calc;
                        if (g_calc == 26'd0)
                            state_reg <= S_LIMITS;
                        else
                        begin
                            div_num_reg <= {27'd0, mod_reg};
                            div_den_reg <= {7'd0, g_calc};
                            div_go_reg  <= 1'b1;
                            state_reg   <= S_GM_W;
                        end
                    end
                    else if (!ga_reg[0] && !gb_reg[0])
                    begin
                        ga_reg <= {1'b0, ga_reg[25:1]};
                        gb_reg <= {1'b0, gb_reg[25:1]};
                        gk_reg <= gk_reg + 5'd1;
                    end
                    else if (!ga_reg[0])
                        ga_reg <= {1'b0, ga_reg[25:1]};
                    else if (!gb_reg[0])
                        gb_reg <= {1'b0, gb_reg[25:1]};
                    else if (ga_reg >= gb_reg)
                        ga_reg <= ga_reg - gb_reg;
                    else
                        gb_reg <= gb_reg - ga_reg;
                end
                S_GM_W:
                begin
                    if (units_idle)
                    begin
                        mod_reg     <= dq_reg[25:0];
                        div_num_reg <= {27'd0, frac_reg};
                        div_den_reg <= {7'd0, g_reg};
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_GF_W;
                    end
                end
                S_GF_W:
                begin
                    if (units_idle)
                    begin
                        frac_reg  <= dq_reg[25:0];
                        state_reg <= S_LIMITS;
                    end
                end
                S_LIMITS:
                begin
                    mod_reg  <= mod_forced;
                    bdiv_reg <= (bdiv_raw > fnpll_pkg::BDIV_MAX) ? 8'd255 : bdiv_raw[7:0];
                    if (mod_forced == 26'd0 || mod_forced > fnpll_pkg::FIELD12_MAX)
                    begin
                        fail_reg  <= fnpll_pkg::ST_MOD_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else if (frac_reg > fnpll_pkg::FIELD12_MAX)
                    begin
                        fail_reg  <= fnpll_pkg::ST_FRAC_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else if ((!band_reg && pfd_reg > fnpll_pkg::PFD_MAX_HZ)
                             || (band_reg && frac_reg != 26'd0
                                 && (pfd_reg > fnpll_pkg::PFD_MAX_HZ
                                     || pfd_reg > fnpll_pkg::PFD_BAND_MAX)))
                    begin
                        fail_reg  <= fnpll_pkg::ST_PFD_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else
                        state_reg <= S_BAND;
                end
                S_BAND:
                begin
                    if ({2'd0, pfd_reg} > fnpll_pkg::BAND_LIM0 * {19'd0, bdiv_reg}
                        || (band_reg
                            && {2'd0, pfd_reg} > fnpll_pkg::BAND_LIM1 * {19'd0, bdiv_reg}))
                    begin
                        fail_reg  <= fnpll_pkg::ST_BAND_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else if (spur_reg && mod_reg < fnpll_pkg::MOD_SPUR_MIN)
                    begin
                        fail_reg  <= fnpll_pkg::ST_MOD_RANGE;
                        state_reg <= S_FAIL;
                    end
                    else
                    begin
                        mul_a_reg  <= {37'd0, nint_reg};
                        mul_b_reg  <= mod_reg;
                        mul_go_reg <= 1'b1;
                        state_reg  <= S_T_W;
                    end
                end
                S_T_W:
                begin
                    if (units_idle)
                    begin
                        mul_a_reg  <= macc_reg + {27'd0, frac_reg};
                        mul_b_reg  <= {1'b0, pfd_reg};
                        mul_go_reg <= 1'b1;
                        state_reg  <= S_TOP_W;
                    end
                end
                S_TOP_W:
                begin
                    if (units_idle)
                    begin
                        div_num_reg <= macc_reg;
                        div_den_reg <= 33'({7'd0, mod_reg} << sel_reg);
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_CALC_W;
                    end
                end
                // exact match when the division leaves nothing and lands on rf
                S_CALC_W:
                begin
                    if (units_idle)
                    begin
                        status_reg    <= (drem_reg == 33'd0 && dq_reg[52:33] == 20'd0
                                          && dq_reg[32:0] == rf_reg)
                                         ? fnpll_pkg::ST_OK : fnpll_pkg::ST_MISMATCH;
                        int_out_reg   <= nint_reg;
                        frac_out_reg  <= frac_reg[11:0];
                        mod_out_reg   <= mod_reg[11:0];
                        presc_out_reg <= presc_reg;
                        r_out_reg     <= r_reg;
                        sel_out_reg   <= sel_reg;
                        bdiv_out_reg  <= bdiv_reg;
                        calc_out_reg  <= (dq_reg[52:33] != 20'd0) ? {33{1'b1}} : dq_reg[32:0];
                        done_reg      <= 1'b1;
                        busy_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_FAIL:
                begin
                    status_reg    <= fail_reg;
                    int_out_reg   <= '0;
                    frac_out_reg  <= '0;
                    mod_out_reg   <= '0;
                    presc_out_reg <= 1'b0;
                    r_out_reg     <= '0;
                    sel_out_reg   <= '0;
                    bdiv_out_reg  <= '0;
                    calc_out_reg  <= '0;
                    done_reg      <= 1'b1;
                    busy_reg      <= 1'b0;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy               = busy_reg;
    assign cfg_ready          = 1'b1;
    assign done               = done_reg;
    assign status             = status_reg;
    assign int_value          = int_out_reg;
    assign frac_value         = frac_out_reg;
    assign mod_value          = mod_out_reg;
    assign prescaler_high     = presc_out_reg;
    assign r_value            = r_out_reg;
    assign rf_div_select      = sel_out_reg;
    assign band_clock_divider = bdiv_out_reg;
    assign rf_out_calc_hz     = calc_out_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while still busy");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(dbusy_reg && mbusy_reg))
        else $error("divider and multiplier active together");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != fnpll_pkg::ST_OK && status != fnpll_pkg::ST_MISMATCH)
        |-> (int_value == 16'd0 && rf_out_calc_hz == 33'd0 && r_value == 10'd0))
        else $error("error result carries nonzero fields");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
